### sv/ppc_pkg.sv
// Shared constants, types and helper functions of the polar pose controller.
package ppc_pkg;

  // Pipeline sizing
  localparam int CORDIC_STAGES = 16;
  localparam int POS_FRAC_BITS = 8;
  localparam int SQRT_STAGES   = 25;   // one result bit per stage, 49-bit radicand
  localparam int SPEED_SHIFT   = POS_FRAC_BITS + 20;
  localparam int STEER_SHIFT   = 40;

  // Fixed-point constants
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] DEG2RAD_Q30 = 34'sd18740330;
  localparam logic signed [22:0] RAD2DEG_Q16 = 23'sd3754936;

  // Register indexes
  typedef enum logic [2:0] {
    REG_GOAL_X        = 3'd0,
    REG_GOAL_Y        = 3'd1,
    REG_GOAL_HEADING  = 3'd2,
    REG_GAIN_DISTANCE = 3'd3,
    REG_GAIN_ALPHA    = 3'd4,
    REG_GAIN_BETA     = 3'd5
  } ppc_reg_e;

  // Rounded atan(2^-i) in Q.30
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    unique case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Truncate toward zero after a right shift, saturate to int16
  function automatic logic [15:0] trunc_sat16(input logic signed [63:0] v, input int s);
    logic        neg;
    logic [63:0] mag;
    logic [15:0] r;
    neg = v[63];
    mag = neg ? (64'd0 - 64'(v)) : 64'(v);
    mag = mag >> s;
    if (neg) begin
      if (mag > 64'd32768) mag = 64'd32768;
      r = 16'(64'd0 - mag);
    end else begin
      if (mag > 64'd32767) mag = 64'd32767;
      r = mag[15:0];
    end
    return r;
  endfunction

endpackage

### sv/ppc_pose_if.sv
// Request channel carrying one measured pose.
interface ppc_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [14:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

### sv/ppc_cmd_if.sv
// Request channel carrying one speed and steering command.
interface ppc_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_cmd;
  logic signed [15:0] steer_deg;

  modport source (output valid, speed_cmd, steer_deg, input ready);
  modport sink   (input valid, speed_cmd, steer_deg, output ready);
endinterface

### sv/polar_pose_controller_top.sv
// Polar pose controller: pipelined distance, bearing and steering computation.
//
// Takes one pose request per cycle while not stalled and returns one command request
// per pose, in order. The path is two setup stages, a 25-stage pipelined square root
// (one result bit per stage) that runs beside the 16-stage vectoring CORDIC, then the
// angle errors, the gain multiplies, the steering sum, the degree conversion and the
// output register. The whole pipeline advances together and holds when the output
// register is full and not taken. Configuration writes land at once and must only be
// issued while no pose is in flight.
module polar_pose_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  ppc_pose_if.sink    pose,
  ppc_cmd_if.source   cmd
);

  localparam int NST = ppc_pkg::SQRT_STAGES;

  // Configuration registers
  logic signed [15:0] goal_x_q, goal_y_q, kp_q, ka_q, kb_q;
  logic signed [8:0]  ghd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= 16'sd0;
      goal_y_q <= 16'sd0;
      ghd_q    <= 9'sd0;
      kp_q     <= 16'sd8192;
      ka_q     <= 16'sd6554;
      kb_q     <= -16'sd2253;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppc_pkg::REG_GOAL_X:        goal_x_q <= cfg_data_i;
        ppc_pkg::REG_GOAL_Y:        goal_y_q <= cfg_data_i;
        ppc_pkg::REG_GOAL_HEADING:  ghd_q    <= cfg_data_i[8:0];
        ppc_pkg::REG_GAIN_DISTANCE: kp_q     <= cfg_data_i;
        ppc_pkg::REG_GAIN_ALPHA:    ka_q     <= cfg_data_i;
        ppc_pkg::REG_GAIN_BETA:     kb_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves when the output slot is free or taken
  logic en;
  logic out_v_q;
  assign en         = !out_v_q || cmd.ready;
  assign pose.ready = en;

  // Stage 1: goal offsets and heading scaling
  logic               v1_q;
  logic signed [16:0] ex_q, ey_q;
  logic signed [32:0] hd1_q;
  logic signed [33:0] grad1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= pose.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q    <= 17'(goal_x_q) - 17'(pose.pos_x);
      ey_q    <= 17'(goal_y_q) - 17'(pose.pos_y);
      hd1_q   <= {pose.heading, 18'b0};
      grad1_q <= 34'(ghd_q) * ppc_pkg::DEG2RAD_Q30;
    end
  end

  // Stage arrays: index 0 is the setup stage, k is after iteration k-1
  logic               v_q    [0:NST];
  logic [49:0]        rem_q  [0:NST];
  logic [49:0]        res_q  [0:NST];
  logic signed [39:0] cx_q   [0:NST];
  logic signed [39:0] cy_q   [0:NST];
  logic signed [33:0] z_q    [0:NST];
  logic               zero_q [0:NST];
  logic signed [32:0] hd_q   [0:NST];
  logic signed [33:0] grad_q [0:NST];

  // Stage 2: squared distance and CORDIC start vector
  logic signed [33:0] exx, eyy;
  logic [32:0]        sq;
  logic signed [39:0] cx0, cy0;
  assign exx = 34'(ex_q) * 34'(ex_q);
  assign eyy = 34'(ey_q) * 34'(ey_q);
  assign sq  = 33'(exx) + 33'(eyy);
  assign cx0 = 40'(ex_q) <<< 20;
  assign cy0 = 40'(ey_q) <<< 20;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en) v_q[0] <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= {1'b0, sq, 16'b0};
      res_q[0]  <= 50'd0;
      cx_q[0]   <= ex_q[16] ? -cx0 : cx0;
      cy_q[0]   <= ex_q[16] ? -cy0 : cy0;
      z_q[0]    <= ex_q[16] ? (ey_q[16] ? -ppc_pkg::PI_Q30 : ppc_pkg::PI_Q30) : 34'sd0;
      zero_q[0] <= (ex_q == 17'sd0) && (ey_q == 17'sd0);
      hd_q[0]   <= hd1_q;
      grad_q[0] <= grad1_q;
    end
  end

  // Square root and CORDIC iteration stages
  for (genvar k = 1; k <= NST; k++) begin : g_stage
    localparam int I = k - 1;
    localparam logic [49:0] BIT = 50'd1 << (2 * (NST - 1) - 2 * I);
    logic [49:0]        trial;
    logic               take;
    logic signed [39:0] cx_n, cy_n;
    logic signed [33:0] z_n;

    assign trial = res_q[k-1] + BIT;
    assign take  = rem_q[k-1] >= trial;

    if (I < ppc_pkg::CORDIC_STAGES) begin : g_rot
      logic signed [39:0] sx, sy;
      assign sx = cx_q[k-1] >>> I;
      assign sy = cy_q[k-1] >>> I;
      always_comb begin
        if (!cy_q[k-1][39]) begin
          cx_n = cx_q[k-1] + sy;
          cy_n = cy_q[k-1] - sx;
          z_n  = z_q[k-1] + ppc_pkg::atan_q30(I);
        end else begin
          cx_n = cx_q[k-1] - sy;
          cy_n = cy_q[k-1] + sx;
          z_n  = z_q[k-1] - ppc_pkg::atan_q30(I);
        end
      end
    end else begin : g_pass
      assign cx_n = cx_q[k-1];
      assign cy_n = cy_q[k-1];
      assign z_n  = z_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k] <= 1'b0;
      else if (en) v_q[k] <= v_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k]  <= take ? (rem_q[k-1] - trial) : rem_q[k-1];
        res_q[k]  <= take ? ((res_q[k-1] >> 1) + BIT) : (res_q[k-1] >> 1);
        cx_q[k]   <= cx_n;
        cy_q[k]   <= cy_n;
        z_q[k]    <= z_n;
        zero_q[k] <= zero_q[k-1];
        hd_q[k]   <= hd_q[k-1];
        grad_q[k] <= grad_q[k-1];
      end
    end
  end

  // Tail stage 1: angle errors
  logic               t1_v_q;
  logic signed [34:0] bear_q, gerr_q;
  logic [24:0]        dist1_q;
  logic signed [33:0] zsel;
  assign zsel = zero_q[NST] ? 34'sd0 : z_q[NST];

  // Tail stage 2: gain products
  logic               t2_v_q;
  logic signed [50:0] pa_q, pb_q;
  logic signed [41:0] sp2_q;

  // Tail stage 3: steering sum to Q.24
  logic               t3_v_q;
  logic signed [33:0] gs_q;
  logic signed [41:0] sp3_q;
  logic signed [51:0] gsum;
  assign gsum = 52'(pa_q) + 52'(pb_q);

  // Tail stage 4: radians to degrees
  logic               t4_v_q;
  logic signed [56:0] deg_q;
  logic signed [41:0] sp4_q;

  // Output register
  logic [15:0] speed_q, steer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q  <= 1'b0;
      t2_v_q  <= 1'b0;
      t3_v_q  <= 1'b0;
      t4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      t1_v_q  <= v_q[NST];
      t2_v_q  <= t1_v_q;
      t3_v_q  <= t2_v_q;
      t4_v_q  <= t3_v_q;
      out_v_q <= t4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bear_q  <= 35'(zsel) - 35'(hd_q[NST]);
      gerr_q  <= 35'(grad_q[NST]) - 35'(zsel);
      dist1_q <= res_q[NST][24:0];
      pa_q    <= 51'(ka_q) * 51'(bear_q);
      pb_q    <= 51'(kb_q) * 51'(gerr_q);
      sp2_q   <= 42'(kp_q) * $signed({17'd0, dist1_q});
      gs_q    <= 34'(gsum >>> 18);
      sp3_q   <= sp2_q;
      deg_q   <= 57'(gs_q) * 57'(ppc_pkg::RAD2DEG_Q16);
      sp4_q   <= sp3_q;
      speed_q <= ppc_pkg::trunc_sat16(64'(sp4_q), ppc_pkg::SPEED_SHIFT);
      steer_q <= ppc_pkg::trunc_sat16(64'(deg_q), ppc_pkg::STEER_SHIFT);
    end
  end

  assign cmd.valid     = out_v_q;
  assign cmd.speed_cmd = speed_q;
  assign cmd.steer_deg = steer_q;

  // Checks
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(t4_v_q))
    else $error("pipeline moved while stalled");

  a_sqrt_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NST] |-> (res_q[NST][49:25] == 25'd0))
    else $error("square root result too wide");

  a_cordic_right_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> !cx_q[0][39])
    else $error("CORDIC start vector not in right half plane");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v1_q && (ex_q == 17'sd0) && (ey_q == 17'sd0)) |=> zero_q[0] && (rem_q[0] == 50'd0))
    else $error("pose at goal not flagged");

endmodule
